>>> design/mfcc_pkg.sv
// Shared types, constants and the CRC-8 byte step for the measurement frame checker.
// No dependencies; every other design file imports this package.
package mfcc_pkg;

  // Frame layout: six groups of high byte, low byte and CRC byte.
  localparam int unsigned GroupCount = 6;
  localparam int unsigned SlotCount  = 3;
  localparam int unsigned WordCount  = 3;

  // Reset values of the configuration registers.
  localparam logic [7:0] CrcInitReset = 8'd255;
  localparam logic [7:0] CrcPolyReset = 8'd49;

  // Largest status code: number of the last word group.
  localparam logic [2:0] MaxStatus = 3'd6;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CRC_INIT = 2'd0,
    REG_CRC_POLY = 2'd1
  } mfcc_reg_e;

  // Slot of a byte inside its group.
  typedef enum logic [1:0] {
    SLOT_HIGH = 2'd0,
    SLOT_LOW  = 2'd1,
    SLOT_CRC  = 2'd2
  } mfcc_slot_e;

  // One received byte with its start flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } mfcc_item_t;

  // Current CRC settings.
  typedef struct packed {
    logic [7:0] crc_init;
    logic [7:0] crc_poly;
  } mfcc_cfg_t;

  // One byte through the CRC-8 register, MSB first.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/mfcc_in_reg.sv
// Input register stage of the measurement frame checker.
// Depends on mfcc_pkg for the item type.
module mfcc_in_reg
  import mfcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  mfcc_item_t in_item_i,
  input  logic       advance_i,
  output logic       item_valid_o,
  output mfcc_item_t item_o
);

  logic       valid_q;
  mfcc_item_t item_q;
  logic       accept;

  // The stage is free when empty or when its word moves on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Valid flag of the held word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> design/mfcc_frame.sv
// Frame tracking, CRC check, word assembly and result register.
// Depends on mfcc_pkg for types, constants and the CRC-8 step.
module mfcc_frame
  import mfcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mfcc_cfg_t   cfg_i,
  input  logic        item_valid_i,
  input  mfcc_item_t  item_i,
  output logic        advance_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] co2_bits_o,
  output logic [31:0] temp_bits_o,
  output logic [31:0] hum_bits_o
);

  // Frame position as group and slot counters.
  logic [2:0]  group_q, group_d, group_cur;
  mfcc_slot_e  slot_q, slot_d, slot_cur;
  logic [7:0]  crc_q, crc_d;
  logic [2:0]  fail_q, fail_d;
  logic [31:0] words_q [WordCount];
  logic [31:0] words_d [WordCount];
  logic        last_byte;
  logic        needs_out;
  logic [1:0]  word_sel;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [31:0] co2_q, temp_q, hum_q;

  // A start flag realigns the frame to its first byte.
  always_comb begin
    if (item_i.frame_start) begin
      group_cur = '0;
      slot_cur  = SLOT_HIGH;
    end else begin
      group_cur = group_q;
      slot_cur  = slot_q;
    end
  end

  assign last_byte = (group_cur == 3'(GroupCount - 1)) && (slot_cur == SLOT_CRC);
  assign needs_out = item_valid_i && last_byte;
  assign advance_o = item_valid_i && (!needs_out || !out_valid_q || !out_stall_i);
  assign word_sel  = group_cur[2:1];

  // Per-byte update of the CRC, the failure record and the words.
  always_comb begin
    crc_d   = crc_q;
    fail_d  = fail_q;
    words_d = words_q;
    group_d = group_cur;
    slot_d  = slot_cur;
    case (slot_cur)
      SLOT_HIGH: begin
        if (group_cur == '0) begin
          fail_d = '0;
        end
        crc_d = crc8_feed(cfg_i.crc_init, item_i.data_byte, cfg_i.crc_poly);
        // The high data byte goes straight into its half; the low byte follows.
        if (!group_cur[0]) begin
          words_d[word_sel][31:24] = item_i.data_byte;
        end else begin
          words_d[word_sel][15:8] = item_i.data_byte;
        end
        slot_d = SLOT_LOW;
      end
      SLOT_LOW: begin
        crc_d = crc8_feed(crc_q, item_i.data_byte, cfg_i.crc_poly);
        if (!group_cur[0]) begin
          words_d[word_sel][23:16] = item_i.data_byte;
        end else begin
          words_d[word_sel][7:0] = item_i.data_byte;
        end
        slot_d = SLOT_CRC;
      end
      SLOT_CRC: begin
        if ((crc_q != item_i.data_byte) && (fail_q == '0)) begin
          fail_d = group_cur + 3'd1;
        end
        slot_d = SLOT_HIGH;
        if (last_byte) begin
          group_d = '0;
        end else begin
          group_d = group_cur + 3'd1;
        end
      end
      default: begin
        slot_d  = SLOT_HIGH;
        group_d = '0;
      end
    endcase
  end

  // Frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      slot_q  <= SLOT_HIGH;
      crc_q   <= '0;
      fail_q  <= '0;
      for (int i = 0; i < WordCount; i++) begin
        words_q[i] <= '0;
      end
    end else if (advance_o) begin
      group_q <= group_d;
      slot_q  <= slot_d;
      crc_q   <= crc_d;
      fail_q  <= fail_d;
      words_q <= words_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o && needs_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with the last byte of a frame.
  always_ff @(posedge clk_i) begin
    if (advance_o && needs_out) begin
      status_q <= fail_d;
      co2_q    <= words_d[0];
      temp_q   <= words_d[1];
      hum_q    <= words_d[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign co2_bits_o  = co2_q;
  assign temp_bits_o = temp_q;
  assign hum_bits_o  = hum_q;

endmodule

>>> design/measurement_frame_crc_checker.sv
// Top level: checks 18-byte sensor frames of three CRC-guarded 32-bit words.
// A frame's last byte is held in the input register and then loads the result register.
// Throughput: one byte per cycle unless a waiting result stalls, set by the input register and the result register.
// A waiting result stalls only the byte that would produce the next result.
// Reset clears the frame position, failure record and words; CRC init and polynomial
// return to 255 and 49. Depends on mfcc_pkg, mfcc_in_reg and mfcc_frame.
module measurement_frame_crc_checker
  import mfcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] co2_bits_o,
  output logic [31:0] temp_bits_o,
  output logic [31:0] hum_bits_o
);

  mfcc_cfg_t  cfg_q;
  mfcc_item_t in_item;
  mfcc_item_t item;
  logic       item_valid;
  logic       advance;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_init <= CrcInitReset;
      cfg_q.crc_poly <= CrcPolyReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CRC_INIT: cfg_q.crc_init <= cfg_data_i;
        REG_CRC_POLY: cfg_q.crc_poly <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.data_byte   = data_byte_i;
  assign in_item.frame_start = frame_start_i;

  mfcc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mfcc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .co2_bits_o   (co2_bits_o),
    .temp_bits_o  (temp_bits_o),
    .hum_bits_o   (hum_bits_o)
  );

  // A reported status is never beyond the last word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= MaxStatus))
    else $error("status out of range");

  // Upstream is stalled only while a byte is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid)
    else $error("stall without a held byte");

  // A new result only follows a byte that moved through the frame stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(advance))
    else $error("result without a processed byte");

endmodule
